[rtl/kdsd_pkg.sv]
// ----------------------------------------------------------------------------
// kdsd_pkg
// Shared types, key codes and helpers for the keypad debounce and
// sequence detector.
// ----------------------------------------------------------------------------
package kdsd_pkg;

	localparam int SEQUENCE_LENGTH = 6;
	localparam int SEQ_POS_W       = 3;
	localparam int IDLE_W          = 16;
	localparam int HOLD_W          = 8;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 16;

	localparam logic [SEQ_POS_W-1:0] SEQ_LAST = SEQ_POS_W'(SEQUENCE_LENGTH - 1);
	localparam logic [IDLE_W-1:0]    IDLE_MAX = '1;

	// decoded key codes
	localparam logic [1:0] CODE_MENU   = 2'd0;
	localparam logic [1:0] CODE_ENTER  = 2'd1;
	localparam logic [1:0] CODE_RETURN = 2'd2;
	localparam logic [1:0] CODE_NONE   = 2'd3;

	// raw pin patterns, low is pressed
	localparam logic [2:0] RAW_MENU   = 3'd6;
	localparam logic [2:0] RAW_ENTER  = 3'd5;
	localparam logic [2:0] RAW_RETURN = 3'd3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_RETURN_TIMEOUT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKLIGHT_TIMEOUT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_LIMIT        = 2'd2;

	typedef struct packed {
		logic [2:0] first_sample;
		logic [2:0] second_sample;
		logic       idle_tick;
		logic       on_home_screen;
	} sample_t;

	typedef struct packed {
		logic       key_event;
		logic [1:0] key_code;
		logic       auto_return;
		logic       beep_request;
		logic       backlight_on;
		logic       soft_reset;
		logic       sound_muted;
		logic       save_settings;
	} result_t;

	typedef struct packed {
		logic [IDLE_W-1:0] return_timeout;
		logic [IDLE_W-1:0] backlight_timeout;
		logic [HOLD_W-1:0] hold_limit;
	} kdsd_cfg_t;

	typedef struct packed {
		logic                 held;
		logic [HOLD_W-1:0]    hold_count;
		logic [IDLE_W-1:0]    idle_count;
		logic                 light_level;
		logic [SEQ_POS_W-1:0] sequence_position;
		logic                 muted_flag;
	} kdsd_state_t;

	function automatic logic [1:0] decode_key(input logic [2:0] raw);
		logic [1:0] k;
		unique case (raw)
			RAW_MENU:   k = CODE_MENU;
			RAW_ENTER:  k = CODE_ENTER;
			RAW_RETURN: k = CODE_RETURN;
			default:    k = CODE_NONE;
		endcase
		return k;
	endfunction

endpackage

[rtl/kdsd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// kdsd_cfg_regs
// Timeout and hold limit registers, written over the configuration channel.
// ----------------------------------------------------------------------------
module kdsd_cfg_regs
	import kdsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output kdsd_cfg_t              cfg
);

	kdsd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.return_timeout    <= IDLE_W'(30);
			cfg_q.backlight_timeout <= IDLE_W'(60);
			cfg_q.hold_limit        <= HOLD_W'(100);
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_RETURN_TIMEOUT:    cfg_q.return_timeout    <= wr_data;
				CFG_BACKLIGHT_TIMEOUT: cfg_q.backlight_timeout <= wr_data;
				CFG_HOLD_LIMIT:        cfg_q.hold_limit        <= wr_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/kdsd_step.sv]
// ----------------------------------------------------------------------------
// kdsd_step
// Next state and result for one scan period: debounce, long press,
// unlock sequence and idle timeouts.
// ----------------------------------------------------------------------------
module kdsd_step
	import kdsd_pkg::*;
(
	input  sample_t     sample,
	input  kdsd_cfg_t   cfg,
	input  kdsd_state_t cur,
	output kdsd_state_t nxt,
	output result_t     res
);

	logic [1:0]        k0, k1;
	logic              same, pressed, idle, press_new;
	logic [IDLE_W-1:0] idle_inc;
	logic [HOLD_W-1:0] hold_inc;
	logic              long_hold;

	always_comb begin
		k0        = decode_key(sample.first_sample);
		k1        = decode_key(sample.second_sample);
		same      = (k0 == k1);
		pressed   = same && (k1 != CODE_NONE);
		idle      = same && (k1 == CODE_NONE);
		press_new = pressed && !cur.held;

		idle_inc = (sample.idle_tick && cur.idle_count != IDLE_MAX)
			? cur.idle_count + IDLE_W'(1) : cur.idle_count;
		hold_inc = cur.hold_count + HOLD_W'(1);

		nxt = cur;
		res = '0;
		nxt.idle_count = idle_inc;

		if (press_new) begin
			res.beep_request = !cur.muted_flag;
			res.key_event    = 1'b1;
			res.key_code     = k1;
			nxt.idle_count   = '0;
			nxt.light_level  = 1'b1;
			// unlock sequence: enters up to the last slot, then menu
			if (cur.sequence_position < SEQ_LAST) begin
				nxt.sequence_position = (k1 == CODE_ENTER)
					? cur.sequence_position + SEQ_POS_W'(1) : '0;
			end else if (cur.sequence_position == SEQ_LAST && k1 == CODE_MENU) begin
				nxt.sequence_position = cur.sequence_position + SEQ_POS_W'(1);
				nxt.muted_flag        = !cur.muted_flag;
				res.save_settings     = 1'b1;
			end else begin
				nxt.sequence_position = '0;
			end
		end

		if (idle && !cur.held) begin
			res.auto_return = (idle_inc >= cfg.return_timeout) && !sample.on_home_screen;
			if (idle_inc >= cfg.backlight_timeout) begin
				nxt.idle_count  = cfg.backlight_timeout;
				nxt.light_level = 1'b0;
			end
		end

		if (pressed) begin
			nxt.held = 1'b1;
		end else if (idle) begin
			nxt.held = 1'b0;
		end

		// hold count advances in the press period too
		long_hold = pressed && (hold_inc > cfg.hold_limit)
			&& (k1 == CODE_ENTER || k1 == CODE_RETURN);
		if (pressed && !long_hold) begin
			nxt.hold_count = hold_inc;
		end else begin
			nxt.hold_count = '0;
		end
		if (long_hold) begin
			res.soft_reset = 1'b1;
			if (!nxt.muted_flag) begin
				res.beep_request = 1'b1;
			end
		end

		res.backlight_on = nxt.light_level;
		res.sound_muted  = nxt.muted_flag;
	end

endmodule

[rtl/keypad_debounce_sequence_detector_unit.sv]
// ----------------------------------------------------------------------------
// keypad_debounce_sequence_detector_unit
// A result is registered and valid in the cycle after its sample transfer.
// Throughput: one sample per cycle unless a held result is stalled; the step
// logic from sample to result register is the only path, state updates in
// the same edge. The result register frees itself when taken, so a new sample
// is taken while the downstream side is not stalling a held result.
// Reset: asynchronous, clears state and result valid, loads register defaults.
// ----------------------------------------------------------------------------
module keypad_debounce_sequence_detector_unit
	import kdsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  sample_t                sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	kdsd_cfg_t   cfg;
	kdsd_state_t state_q, state_nxt;
	result_t     res_nxt, result_q;
	logic        result_valid_q;
	logic        take;

	assign cfg_ready = 1'b1;

	kdsd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	kdsd_step u_step (
		.sample (sample),
		.cfg    (cfg),
		.cur    (state_q),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	// stall only while a held result is itself stalled
	assign sample_stall = result_valid_q && result_stall;
	assign take         = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q        <= state_nxt;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the keypad debounce and sequence detector against a cycle-free
// behavioural predictor. Scan periods go in through a queue-fed driver with
// random bursts and gaps; results are taken under a rotating stall pattern
// and compared field by field. Covers debounce, unlock sequence, long hold,
// idle timeouts and hold count wrap.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kdsd_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	sample_t                sample = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	keypad_debounce_sequence_detector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// predictor configuration, mirrors register writes
	logic [IDLE_W-1:0] return_limit = 16'd30;
	logic [IDLE_W-1:0] dark_limit   = 16'd60;
	logic [HOLD_W-1:0] hold_max     = 8'd100;

	// predictor state
	logic                 key_held   = 1'b0;
	logic [HOLD_W-1:0]    hold_run   = '0;
	logic [IDLE_W-1:0]    idle_ticks = '0;
	logic                 light      = 1'b0;
	logic [SEQ_POS_W-1:0] seq_pos    = '0;
	logic                 muted      = 1'b0;

	sample_t     pending_samples[$];
	result_t     expected_results[$];
	int unsigned queued_items = 0;
	int unsigned mismatches = 0;

	// sender bursts and receiver stall pattern
	int unsigned gap_max = 0;
	int unsigned gap_left = 0;
	int unsigned burst_left = 1;
	logic [15:0] stall_pattern = '0;
	logic [3:0]  stall_step = '0;

	function automatic logic [1:0] key_of(input logic [2:0] raw);
		case (raw)
			RAW_MENU:   return CODE_MENU;
			RAW_ENTER:  return CODE_ENTER;
			RAW_RETURN: return CODE_RETURN;
			default:    return CODE_NONE;
		endcase
	endfunction

	// one scan period: updates the predicted state, returns the expected result
	function automatic result_t scan_period(input sample_t s);
		logic [1:0] k0;
		logic [1:0] k1;
		logic       pressed;
		logic       idle;
		result_t    r;
		k0 = key_of(s.first_sample);
		k1 = key_of(s.second_sample);
		pressed = (k0 == k1) && (k1 != CODE_NONE);
		idle = (k0 == k1) && (k1 == CODE_NONE);
		r = '0;
		if (s.idle_tick && idle_ticks != IDLE_MAX)
			idle_ticks = idle_ticks + 1'b1;
		if (pressed && !key_held) begin
			// beep follows the mute setting from before any toggle
			r.beep_request = !muted;
			key_held = 1'b1;
			idle_ticks = '0;
			light = 1'b1;
			if (seq_pos < SEQ_LAST) begin
				seq_pos = (k1 == CODE_ENTER) ? seq_pos + 1'b1 : '0;
			end else if (seq_pos == SEQ_LAST && k1 == CODE_MENU) begin
				seq_pos = seq_pos + 1'b1;
				muted = !muted;
				r.save_settings = 1'b1;
			end else begin
				seq_pos = '0;
			end
			r.key_event = 1'b1;
			r.key_code = k1;
		end
		if (idle && !key_held) begin
			if (idle_ticks >= return_limit && !s.on_home_screen)
				r.auto_return = 1'b1;
			if (idle_ticks >= dark_limit) begin
				idle_ticks = dark_limit;
				light = 1'b0;
			end
		end
		if (idle && key_held)
			key_held = 1'b0;
		if (pressed && key_held) begin
			hold_run = hold_run + 1'b1;
			if (hold_run > hold_max && (k1 == CODE_ENTER || k1 == CODE_RETURN)) begin
				if (!muted)
					r.beep_request = 1'b1;
				r.soft_reset = 1'b1;
				hold_run = '0;
			end
		end else begin
			hold_run = '0;
		end
		r.backlight_on = light;
		r.sound_muted = muted;
		return r;
	endfunction

	// sender: bursts of random length, random gaps between them
	always @(posedge clk) begin
		logic next_valid;
		if (arst_n) begin
			next_valid = sample_valid;
			if (sample_valid && !sample_stall) begin
				expected_results.push_back(scan_period(sample));
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_samples.size() != 0) begin
					sample <= pending_samples.pop_front();
					next_valid = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
					end
				end
			end
			sample_valid <= next_valid;
		end
	end

	// receiver: stall pattern and result check
	always @(posedge clk) begin
		result_t want;
		string   bad;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result transfer with nothing expected, got %b",
							$time, result);
				end else begin
					want = expected_results.pop_front();
					bad = "";
					if (result.key_event !== want.key_event) bad = {bad, " key_event"};
					if (result.key_code !== want.key_code) bad = {bad, " key_code"};
					if (result.auto_return !== want.auto_return) bad = {bad, " auto_return"};
					if (result.beep_request !== want.beep_request)
						bad = {bad, " beep_request"};
					if (result.backlight_on !== want.backlight_on)
						bad = {bad, " backlight_on"};
					if (result.soft_reset !== want.soft_reset) bad = {bad, " soft_reset"};
					if (result.sound_muted !== want.sound_muted) bad = {bad, " sound_muted"};
					if (result.save_settings !== want.save_settings)
						bad = {bad, " save_settings"};
					if (bad != "") begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch in%s: expected %b got %b",
								$time, bad, want, result);
					end
				end
			end
			stall_step <= stall_step + 1'b1;
			result_stall <= stall_pattern[stall_step];
		end
	end

	task automatic queue_sample(input logic [2:0] first, input logic [2:0] second,
			input logic tick, input logic home);
		sample_t s;
		s.first_sample = first;
		s.second_sample = second;
		s.idle_tick = tick;
		s.on_home_screen = home;
		pending_samples.push_back(s);
		queued_items++;
	endtask

	function automatic logic [2:0] none_raw();
		case ($urandom_range(0, 4))
			0:       return 3'd0;
			1:       return 3'd1;
			2:       return 3'd2;
			3:       return 3'd4;
			default: return 3'd7;
		endcase
	endfunction

	function automatic logic [2:0] press_raw();
		case ($urandom_range(0, 2))
			0:       return RAW_MENU;
			1:       return RAW_ENTER;
			default: return RAW_RETURN;
		endcase
	endfunction

	task automatic queue_press(input logic [2:0] raw, input int unsigned periods);
		repeat (periods)
			queue_sample(raw, raw, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic queue_release(input int unsigned periods);
		repeat (periods)
			queue_sample(none_raw(), none_raw(), $urandom_range(0, 3) != 0,
				1'($urandom_range(0, 1)));
	endtask

	// mostly well-formed key sequences with random content, some noise
	task automatic random_traffic(input int unsigned count);
		int unsigned target;
		int unsigned pick;
		logic [2:0]  key;
		target = queued_items + count;
		while (queued_items < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				for (int i = 0; i < SEQUENCE_LENGTH; i++) begin
					key = (i == SEQUENCE_LENGTH - 1) ? RAW_MENU : RAW_ENTER;
					if ($urandom_range(0, 19) == 0)
						key = press_raw();
					queue_press(key, $urandom_range(1, 3));
					// contact bounce between the two samples
					if ($urandom_range(0, 9) == 0)
						queue_sample(key, none_raw(), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
					queue_release($urandom_range(1, 2));
				end
			end else if (pick < 55) begin
				queue_press(press_raw(), $urandom_range(1, hold_max + 4));
				queue_release(1);
			end else if (pick < 75) begin
				queue_release($urandom_range(1, 40));
			end else begin
				repeat ($urandom_range(1, 8))
					queue_sample(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_RETURN_TIMEOUT:    return_limit = value;
			CFG_BACKLIGHT_TIMEOUT: dark_limit = value;
			CFG_HOLD_LIMIT:        hold_max = value[HOLD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_limits(input logic [15:0] ret, input logic [15:0] dark,
			input logic [7:0] hold);
		cfg_write(CFG_RETURN_TIMEOUT, ret);
		cfg_write(CFG_BACKLIGHT_TIMEOUT, dark);
		cfg_write(CFG_HOLD_LIMIT, 16'(hold));
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: short timeouts so every path shows in a few periods
		set_limits(16'd2, 16'd4, 8'd2);
		queue_sample(3'd7, 3'd7, 1'b1, 1'b0);
		queue_sample(3'd0, 3'd0, 1'b1, 1'b1);
		queue_sample(3'd7, 3'd0, 1'b1, 1'b0);
		queue_sample(RAW_MENU, RAW_MENU, 1'b1, 1'b0);
		queue_sample(RAW_ENTER, RAW_RETURN, 1'b0, 1'b0);
		queue_sample(3'd4, 3'd2, 1'b1, 1'b1);
		queue_press(RAW_ENTER, 4);
		queue_sample(3'd1, 3'd1, 1'b0, 1'b0);
		queue_press(RAW_RETURN, 1);
		queue_release(1);
		// unlock sequence, then the key right after it
		repeat (SEQUENCE_LENGTH - 1) begin
			queue_press(RAW_ENTER, 1);
			queue_release(1);
		end
		queue_press(RAW_MENU, 1);
		queue_release(1);
		queue_press(RAW_ENTER, 1);
		repeat (6)
			queue_sample(3'd7, 3'd7, 1'b1, 1'b0);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       set_limits(16'd30, 16'd60, 8'd100);
				1:       set_limits(16'd0, 16'd0, 8'd0);
				2:       set_limits(16'hFFFF, 16'hFFFF, 8'hFF);
				default: set_limits(16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)),
					8'($urandom_range(0, 15)));
			endcase
			gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 6);
			stall_pattern = (phase % 3 == 1) ? '0 : 16'($urandom) & 16'hFFFE;
			random_traffic(60);
			drain();
		end

		// hold count wraps: long menu hold, then enter without releasing
		set_limits(16'd5, 16'd10, 8'd10);
		gap_max = 2;
		stall_pattern = 16'h0104;
		queue_release(2);
		queue_press(RAW_MENU, 258);
		queue_press(RAW_ENTER, 12);
		queue_release(2);
		drain();

		// long idle run past both timeouts, flat out on both sides
		set_limits(16'd12, 16'd25, 8'd20);
		gap_max = 0;
		stall_pattern = '0;
		repeat (40)
			queue_sample(none_raw(), none_raw(), 1'b1, 1'($urandom_range(0, 1)));
		random_traffic(20);
		drain();

		repeat (4) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
